FILE: rtl/core/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Types, function codes and the built-in melody table of the buzzer melody
// sequencer.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_PLAY    = 2'd1;
  localparam logic [1:0] FUNC_ENQUEUE = 2'd2;

  localparam int          NUM_MELODIES = 6;
  localparam logic [2:0]  MELODY_LAST  = 3'd5;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] sound_id;
  } bms_in_t;

  typedef struct packed {
    logic        tone_write;
    logic [10:0] tone_freq;
    logic        playing;
    logic        dropped;
  } bms_out_t;

  // Tone frequency in Hz of note n of melody m; past the end it reads 0.
  function automatic logic [10:0] note_freq(logic [2:0] m, logic [2:0] n);
    logic [10:0] f;
    f = 11'd0;
    case ({m, n})
      // Success
      6'o00: f = 11'd988;
      6'o01: f = 11'd1480;
      6'o02: f = 11'd1976;
      // Fail
      6'o10: f = 11'd1976;
      6'o11: f = 11'd1175;
      6'o12: f = 11'd784;
      // Wait: three beeps with pauses
      6'o20: f = 11'd1480;
      6'o22: f = 11'd1480;
      6'o24: f = 11'd1480;
      // Boot
      6'o30: f = 11'd784;
      6'o31: f = 11'd1175;
      6'o32: f = 11'd1568;
      6'o33: f = 11'd1976;
      // Start
      6'o40: f = 11'd262;
      6'o41: f = 11'd196;
      6'o42: f = 11'd196;
      6'o43: f = 11'd220;
      6'o44: f = 11'd196;
      6'o46: f = 11'd247;
      6'o47: f = 11'd262;
      // Jingle
      6'o50: f = 11'd523;
      6'o51: f = 11'd659;
      6'o52: f = 11'd784;
      6'o53: f = 11'd1047;
      default: f = 11'd0;
    endcase
    return f;
  endfunction

  // Duration in ms of note n of melody m.
  function automatic logic [8:0] note_ms(logic [2:0] m, logic [2:0] n);
    logic [8:0] d;
    d = 9'd0;
    case ({m, n})
      6'o00: d = 9'd100;
      6'o01: d = 9'd120;
      6'o02: d = 9'd150;
      6'o10: d = 9'd150;
      6'o11: d = 9'd200;
      6'o12: d = 9'd300;
      6'o20, 6'o22, 6'o24: d = 9'd100;
      6'o21, 6'o23, 6'o25: d = 9'd400;
      6'o30, 6'o31, 6'o32: d = 9'd100;
      6'o33: d = 9'd150;
      6'o41, 6'o42: d = 9'd163;
      6'o40, 6'o43, 6'o44, 6'o45, 6'o46, 6'o47: d = 9'd325;
      6'o50, 6'o51, 6'o52: d = 9'd120;
      6'o53: d = 9'd180;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Number of notes in melody m.
  function automatic logic [3:0] note_count(logic [2:0] m);
    logic [3:0] c;
    c = 4'd0;
    case (m)
      3'd0: c = 4'd3;
      3'd1: c = 4'd3;
      3'd2: c = 4'd6;
      3'd3: c = 4'd4;
      3'd4: c = 4'd8;
      3'd5: c = 4'd4;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/bms_ram.sv
// ----------------------------------------------------------------------------
// bms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/buzzer_melody_sequencer_unit.sv
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer_unit
// Buzzer tone sequencer: plays melodies from a built-in note table, keeps a
// ring queue of melody ids in RAM and advances notes on millisecond ticks.
//
//   Channel | Signals                      | Direction | Payload
//   --------+------------------------------+-----------+-----------
//   input   | in_valid, in_ready, in_data  | in        | bms_in_t
//   output  | out_valid, out_ready, out_data | out     | bms_out_t
//
// Each item is accepted in S_IDLE while the queue RAM reads the head slot,
// then S_EXEC updates the state and loads the result register. A new item
// is accepted only in S_IDLE, once the result register is empty or being
// drained in the same cycle, so at most one item is in flight.
// Reset is synchronous and clears all control state; queue RAM contents are
// not cleared, only written slots are ever read.
// ----------------------------------------------------------------------------
module buzzer_melody_sequencer_unit
  import bms_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bms_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bms_out_t out_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Control and melody state.
  logic          state;
  bms_in_t       item;
  logic          current_valid;
  logic [2:0]    current_melody;
  logic [3:0]    note_index;
  logic          tone_on;
  logic [15:0]   elapsed_ms;
  logic [PW-1:0] queue_head;
  logic [PW-1:0] queue_tail;

  logic          current_valid_next;
  logic [2:0]    current_melody_next;
  logic [3:0]    note_index_next;
  logic          tone_on_next;
  logic [15:0]   elapsed_ms_next;
  logic [PW-1:0] queue_head_next;
  logic [PW-1:0] queue_tail_next;
  bms_out_t      result;

  // Queue RAM port signals.
  logic          q_wr_en;
  logic [2:0]    q_rd_data;

  logic          accept;
  logic [15:0]   elapsed_inc;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic [3:0]    index_inc;
  logic [10:0]   cur_freq;
  logic [8:0]    cur_ms;
  logic          id_ok;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // Melody queue; the read port always follows the head pointer.
  bms_ram #(
    .WIDTH(3),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .wr_en  (q_wr_en),
    .wr_addr(queue_tail),
    .wr_data(item.sound_id),
    .rd_addr(queue_head),
    .rd_data(q_rd_data)
  );

  // Pointer steps and the current note lookup.
  assign head_inc    = (queue_head == PTR_LAST) ? '0 : queue_head + 1'b1;
  assign tail_inc    = (queue_tail == PTR_LAST) ? '0 : queue_tail + 1'b1;
  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 16'd1;
  assign index_inc   = note_index + 4'd1;
  assign cur_freq    = note_freq(current_melody, note_index[2:0]);
  assign cur_ms      = note_ms(current_melody, note_index[2:0]);
  assign id_ok       = (item.sound_id <= MELODY_LAST);

  // Item execution: next state and result.
  always_comb begin
    current_valid_next  = current_valid;
    current_melody_next = current_melody;
    note_index_next     = note_index;
    tone_on_next        = tone_on;
    elapsed_ms_next     = elapsed_ms;
    queue_head_next     = queue_head;
    queue_tail_next     = queue_tail;
    q_wr_en             = 1'b0;
    result              = '0;

    case (item.func)
      FUNC_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (!current_valid) begin
          // Idle: pick up the next queued melody, if any.
          if (queue_head != queue_tail) begin
            current_melody_next = q_rd_data;
            queue_head_next     = head_inc;
            current_valid_next  = 1'b1;
            note_index_next     = 4'd0;
            tone_on_next        = 1'b0;
          end
        end else if (!tone_on) begin
          // Start the current note.
          result.tone_write = 1'b1;
          result.tone_freq  = cur_freq;
          elapsed_ms_next   = 16'd0;
          tone_on_next      = 1'b1;
        end else if (elapsed_inc >= {7'd0, cur_ms}) begin
          // Note over: silence and advance.
          result.tone_write = 1'b1;
          tone_on_next      = 1'b0;
          elapsed_ms_next   = 16'd0;
          note_index_next   = index_inc;
          if (index_inc >= note_count(current_melody)) begin
            if (queue_head == queue_tail) begin
              current_valid_next = 1'b0;
            end else begin
              current_melody_next = q_rd_data;
              queue_head_next     = head_inc;
              note_index_next     = 4'd0;
            end
          end
        end
      end
      FUNC_PLAY: begin
        if (id_ok) begin
          queue_head_next     = '0;
          queue_tail_next     = '0;
          current_valid_next  = 1'b1;
          current_melody_next = item.sound_id;
          note_index_next     = 4'd0;
          tone_on_next        = 1'b0;
          elapsed_ms_next     = 16'd0;
        end
      end
      FUNC_ENQUEUE: begin
        if (id_ok) begin
          if (tail_inc == queue_head) begin
            result.dropped = 1'b1;
          end else begin
            // The slot is written only in the cycle that executes the item.
            q_wr_en         = (state == S_EXEC);
            queue_tail_next = tail_inc;
          end
        end
      end
      default: begin
      end
    endcase

    result.playing = current_valid_next || (queue_head_next != queue_tail_next);
  end

  // Sequencer, state registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      current_valid  <= 1'b0;
      current_melody <= 3'd0;
      note_index     <= 4'd0;
      tone_on        <= 1'b0;
      elapsed_ms     <= 16'd0;
      queue_head     <= '0;
      queue_tail     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state          <= S_IDLE;
          out_valid      <= 1'b1;
          current_valid  <= current_valid_next;
          current_melody <= current_melody_next;
          note_index     <= note_index_next;
          tone_on        <= tone_on_next;
          elapsed_ms     <= elapsed_ms_next;
          queue_head     <= queue_head_next;
          queue_tail     <= queue_tail_next;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (state == S_EXEC) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // An accepted item is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item not executed");

  // The result register is never overwritten while it holds a result.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (!out_valid || out_ready))
    else $error("result register overrun");

  // Silence is reported whenever no tone is written.
  a_freq_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.tone_write) |-> (out_data.tone_freq == 11'd0))
    else $error("frequency without tone write");

  // A full queue is never empty, so a dropped request reports playing.
  a_drop_playing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped) |-> out_data.playing)
    else $error("dropped request without playing status");
`endif

endmodule
